FILE: rtl/core/http_request_header_parser_defines.svh
// Assertion macros shared by the parser RTL.
`ifndef HTTP_REQUEST_HEADER_PARSER_DEFINES_SVH
`define HTTP_REQUEST_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define HRHP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define HRHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/hrhp_pkg.sv
package hrhp_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_HEADERS_DEF = 16;
    localparam int OFFSET_BITS_DEF = 16;
    // Table limit never exceeds what the 5-bit register can ask for
    localparam int MAX_HEADERS_CAP = 31;

    localparam logic [4:0] MAX_HEADERS_RESET = 5'd16;

    // Token shift register: last eight bytes, saturating byte count
    localparam int TOKEN_W = 64;
    localparam logic [3:0] TOKEN_CNT_MAX = 4'd15;

    // Result queue
    localparam int RES_DEPTH = 4;

    // Characters of interest
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_PATH,
        PH_VERSION,
        PH_KEY,
        PH_VALUE,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [2:0] {
        EV_METHOD,
        EV_PATH,
        EV_VERSION,
        EV_KEY,
        EV_VALUE,
        EV_HEADERS_END,
        EV_ERROR,
        EV_EXHAUSTED
    } event_kind_t;

    // Error codes
    localparam logic [2:0] ERR_METHOD     = 3'd0;
    localparam logic [2:0] ERR_VERSION    = 3'd1;
    localparam logic [2:0] ERR_NO_ROOM    = 3'd2;
    localparam logic [2:0] ERR_TABLE_FULL = 3'd3;
    localparam logic [2:0] CODE_NONE      = 3'd0;

    // Method and version tokens, right-aligned, earliest byte highest
    localparam int METHOD_NUM  = 5;
    localparam int VERSION_NUM = 3;

    localparam logic [TOKEN_W-1:0] METHOD_TOK [METHOD_NUM] = '{
        64'("GET"), 64'("POST"), 64'("PUSH"), 64'("DELETE"), 64'("CONNECT")
    };
    localparam logic [3:0] METHOD_LEN [METHOD_NUM] = '{4'd3, 4'd4, 4'd4, 4'd6, 4'd7};

    localparam logic [TOKEN_W-1:0] VERSION_TOK [VERSION_NUM] = '{
        64'("HTTP/1.0"), 64'("HTTP/1.1"), 64'("HTTP/2.0")
    };
    localparam logic [3:0] VERSION_LEN [VERSION_NUM] = '{4'd8, 4'd8, 4'd8};

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } match_t;

    // One result record
    typedef struct packed {
        event_kind_t kind;
        logic [2:0]  code;
        logic [15:0] start;
        logic [15:0] length;
        logic [4:0]  index;
        logic        last;
    } result_t;

    // Results produced by one byte, handed to the queue
    typedef struct packed {
        logic [1:0] count;
        result_t    rec0;
        result_t    rec1;
    } result_push_t;

    function automatic match_t match_method(logic [TOKEN_W-1:0] tok, logic [3:0] cnt);
        match_t m;
        m = '0;
        for (int k = 0; k < METHOD_NUM; k++) begin
            if (!m.hit && cnt == METHOD_LEN[k] && tok == METHOD_TOK[k]) begin
                m.hit  = 1'b1;
                m.code = 3'(k);
            end
        end
        return m;
    endfunction

    function automatic match_t match_version(logic [TOKEN_W-1:0] tok, logic [3:0] cnt);
        match_t m;
        m = '0;
        for (int k = 0; k < VERSION_NUM; k++) begin
            if (!m.hit && cnt == VERSION_LEN[k] && tok == VERSION_TOK[k]) begin
                m.hit  = 1'b1;
                m.code = 3'(k);
            end
        end
        return m;
    endfunction

    function automatic result_t make_rec(event_kind_t kind, logic [2:0] code,
                                         logic [15:0] start, logic [15:0] length,
                                         logic [4:0] index);
        result_t r;
        r.kind   = kind;
        r.code   = code;
        r.start  = start;
        r.length = length;
        r.index  = index;
        r.last   = 1'b0;
        return r;
    endfunction

endpackage

FILE: rtl/core/hrhp_if.sv
// Request byte channel
interface hrhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result record channel
interface hrhp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [2:0]  kind_code;
    logic [15:0] field_start;
    logic [15:0] field_length;
    logic [4:0]  header_index;
    logic        last_result;

    modport source (output valid, output event_kind, output kind_code, output field_start,
                    output field_length, output header_index, output last_result,
                    input ready);
    modport sink   (input valid, input event_kind, input kind_code, input field_start,
                    input field_length, input header_index, input last_result,
                    output ready);
endinterface

// Configuration write channel (max_headers)
interface hrhp_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] max_headers;

    modport source (output valid, output max_headers, input ready);
    modport sink   (input valid, input max_headers, output ready);
endinterface

FILE: rtl/core/http_request_header_parser.sv
// HTTP/1 request header parser. Request bytes arrive on byte_stream, one per
// transaction, and each byte is held in an input register and parsed from
// there once the result queue has room, so a new byte can be accepted every
// clock while the queue keeps room. The only loop is the parser state
// register updated once per byte. A byte yields zero, one or two records
// (a field record, optionally followed by an error or buffer exhausted
// record); these go through a four-entry result queue that drives
// result_stream, so the sustained rate is one byte per cycle while the sink
// keeps up and while records average at most one per byte. A byte's first
// record passes through the input register and then the result queue before
// it appears on result_stream. max_headers is written on cfg, only while the
// parser is idle, a rule for the user that the block itself does not enforce;
// it resets to 16 and survives the restart that follows a byte flagged last_byte.
module http_request_header_parser #(
    parameter int MAX_HEADERS = hrhp_pkg::MAX_HEADERS_DEF,
    parameter int OFFSET_BITS = hrhp_pkg::OFFSET_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    hrhp_in_if.sink    byte_stream,
    hrhp_out_if.source result_stream,
    hrhp_cfg_if.sink   cfg
);
    import hrhp_pkg::*;

    logic [4:0]   max_headers_reg;
    logic         room;
    result_push_t push;

    // Configuration register, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_headers_reg <= MAX_HEADERS_RESET;
        end
        else if (cfg.valid)
        begin
            max_headers_reg <= cfg.max_headers;
        end
    end

    // Byte parser
    hrhp_parse_core #(
        .MAX_HEADERS (MAX_HEADERS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parse_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .max_headers (max_headers_reg),
        .room        (room),
        .push        (push)
    );

    // Result queue
    hrhp_result_fifo u_result_fifo (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .room          (room),
        .result_stream (result_stream)
    );

endmodule

FILE: rtl/core/hrhp_parse_core.sv
`include "http_request_header_parser_defines.svh"

module hrhp_parse_core #(
    parameter int MAX_HEADERS = hrhp_pkg::MAX_HEADERS_DEF,
    parameter int OFFSET_BITS = hrhp_pkg::OFFSET_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    hrhp_in_if.sink               byte_stream,
    input  logic [4:0]            max_headers,
    input  logic                  room,
    output hrhp_pkg::result_push_t push
);
    import hrhp_pkg::*;

    localparam int LIMIT_CAP = (MAX_HEADERS > MAX_HEADERS_CAP) ? MAX_HEADERS_CAP : MAX_HEADERS;
    localparam logic [4:0] LIMIT_MAX = 5'(LIMIT_CAP);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       proc;

    // Parser state
    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] ts_reg, ts_next;
    logic [TOKEN_W-1:0]     tok_reg, tok_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic                   cs_reg, cs_next;
    logic [4:0]             entry_reg, entry_next;
    logic                   vb_reg, vb_next;

    // Datapath intermediates
    logic [7:0]             b;
    logic [OFFSET_BITS-1:0] nxt;
    logic [OFFSET_BITS-1:0] len_a;
    logic [OFFSET_BITS-1:0] len_b;
    logic [4:0]             limit;
    logic [4:0]             entry_inc;
    logic                   cr_phase;
    logic                   line_end;
    logic                   push_cr;
    logic [TOKEN_W-1:0]     tok_cr;
    logic [3:0]             cnt_cr;
    match_t                 m;
    logic                   prim_v, err_v, exh_v;
    result_t                prim, err, exh;
    logic [1:0]             n_res;

    assign proc              = in_valid_reg && room;
    assign byte_stream.ready = !in_valid_reg || proc;

    // Input register: refilled when empty or when the held byte moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_stream.ready)
        begin
            in_valid_reg <= byte_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_stream.valid && byte_stream.ready)
        begin
            in_byte_reg <= byte_stream.data_byte;
            in_last_reg <= byte_stream.last_byte;
        end
    end

    assign b         = in_byte_reg;
    assign nxt       = pos_reg + OFFSET_BITS'(1);
    assign len_a     = pos_reg - ts_reg;
    assign len_b     = pos_reg - ts_reg - OFFSET_BITS'(1);
    assign limit     = (max_headers < LIMIT_MAX) ? max_headers : LIMIT_MAX;
    assign entry_inc = entry_reg + 5'd1;

    // CR LF detection, CR possibly held from the previous byte
    assign cr_phase = (phase_reg == PH_VERSION) || (phase_reg == PH_KEY) ||
                      (phase_reg == PH_VALUE);
    assign line_end = cr_phase && cs_reg && (b == CH_LF);
    assign push_cr  = cr_phase && cs_reg && (b != CH_LF);
    assign tok_cr   = push_cr ? {tok_reg[TOKEN_W-9:0], CH_CR} : tok_reg;
    assign cnt_cr   = (push_cr && cnt_reg != TOKEN_CNT_MAX) ? cnt_reg + 4'd1 : cnt_reg;

    // Next state and results for the held byte
    always_comb
    begin
        phase_next = phase_reg;
        ts_next    = ts_reg;
        tok_next   = tok_reg;
        cnt_next   = cnt_reg;
        cs_next    = cs_reg;
        entry_next = entry_reg;
        vb_next    = vb_reg;
        pos_next   = nxt;
        m          = '0;
        prim_v     = 1'b0;
        err_v      = 1'b0;
        prim       = '0;
        err        = make_rec(EV_ERROR, CODE_NONE, 16'(pos_reg), 16'd0, 5'd0);
        exh        = make_rec(EV_EXHAUSTED, CODE_NONE, 16'(nxt), 16'd0, 5'd0);

        if (cr_phase)
        begin
            cs_next = !line_end && (b == CH_CR);
        end

        case (phase_reg)
            PH_METHOD:
            begin
                if (b == CH_SPACE)
                begin
                    m      = match_method(tok_reg, cnt_reg);
                    prim_v = 1'b1;
                    if (!m.hit)
                    begin
                        prim       = make_rec(EV_ERROR, ERR_METHOD, 16'(pos_reg), 16'd0, 5'd0);
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        prim       = make_rec(EV_METHOD, m.code, 16'(ts_reg), 16'(len_a), 5'd0);
                        phase_next = PH_PATH;
                        ts_next    = nxt;
                    end
                    tok_next = '0;
                    cnt_next = '0;
                    cs_next  = 1'b0;
                end
                else
                begin
                    tok_next = {tok_reg[TOKEN_W-9:0], b};
                    cnt_next = (cnt_reg != TOKEN_CNT_MAX) ? cnt_reg + 4'd1 : cnt_reg;
                end
            end
            PH_PATH:
            begin
                if (b == CH_SPACE)
                begin
                    prim_v     = 1'b1;
                    prim       = make_rec(EV_PATH, CODE_NONE, 16'(ts_reg), 16'(len_a), 5'd0);
                    phase_next = PH_VERSION;
                    ts_next    = nxt;
                    tok_next   = '0;
                    cnt_next   = '0;
                    cs_next    = 1'b0;
                end
            end
            PH_VERSION:
            begin
                if (line_end)
                begin
                    m      = match_version(tok_reg, cnt_reg);
                    prim_v = 1'b1;
                    if (!m.hit)
                    begin
                        prim = make_rec(EV_ERROR, ERR_VERSION, 16'(pos_reg), 16'd0, 5'd0);
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        prim = make_rec(EV_VERSION, m.code, 16'(ts_reg), 16'(len_b), 5'd0);
                        entry_next = 5'd0;
                        if (limit == 5'd0)
                        begin
                            err_v      = 1'b1;
                            err.code   = ERR_NO_ROOM;
                            phase_next = PH_ERROR;
                        end
                        else
                        begin
                            phase_next = PH_KEY;
                            ts_next    = nxt;
                        end
                    end
                    tok_next = '0;
                    cnt_next = '0;
                    cs_next  = 1'b0;
                end
                else if (b != CH_CR)
                begin
                    tok_next = {tok_cr[TOKEN_W-9:0], b};
                    cnt_next = (cnt_cr != TOKEN_CNT_MAX) ? cnt_cr + 4'd1 : cnt_cr;
                end
                else
                begin
                    tok_next = tok_cr;
                    cnt_next = cnt_cr;
                end
            end
            PH_KEY:
            begin
                if (line_end)
                begin
                    prim_v     = 1'b1;
                    prim       = make_rec(EV_HEADERS_END, CODE_NONE, 16'(nxt), 16'd0, entry_reg);
                    phase_next = PH_DONE;
                end
                else if (b == CH_COLON)
                begin
                    prim_v     = 1'b1;
                    prim       = make_rec(EV_KEY, CODE_NONE, 16'(ts_reg), 16'(len_a), entry_reg);
                    phase_next = PH_VALUE;
                    ts_next    = nxt;
                    vb_next    = 1'b0;
                    cs_next    = 1'b0;
                end
            end
            PH_VALUE:
            begin
                if (line_end)
                begin
                    prim_v     = 1'b1;
                    prim       = make_rec(EV_VALUE, CODE_NONE, 16'(ts_reg), 16'(len_b), entry_reg);
                    entry_next = entry_inc;
                    if (entry_inc >= limit)
                    begin
                        err_v      = 1'b1;
                        err.code   = ERR_TABLE_FULL;
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        phase_next = PH_KEY;
                        ts_next    = nxt;
                    end
                end
                else if (b == CH_SPACE && !vb_reg)
                begin
                    // leading value space: value starts later
                    ts_next = nxt;
                end
                else
                begin
                    vb_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // End of buffer: report an open parse, then start afresh
        exh_v = in_last_reg && (phase_next != PH_DONE) && (phase_next != PH_ERROR);
        if (in_last_reg)
        begin
            phase_next = PH_METHOD;
            pos_next   = '0;
            ts_next    = '0;
            tok_next   = '0;
            cnt_next   = '0;
            cs_next    = 1'b0;
            entry_next = 5'd0;
            vb_next    = 1'b0;
        end
    end

    // Order results and mark the final one
    always_comb
    begin
        n_res     = 2'(prim_v) + 2'(err_v) + 2'(exh_v);
        push.rec0 = prim_v ? prim : exh;
        push.rec1 = err_v ? err : exh;
        push.rec0.last = (n_res == 2'd1);
        push.rec1.last = 1'b1;
        push.count = proc ? n_res : 2'd0;
    end

    // State registers advance once per processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_METHOD;
            pos_reg   <= '0;
            ts_reg    <= '0;
            tok_reg   <= '0;
            cnt_reg   <= '0;
            cs_reg    <= 1'b0;
            entry_reg <= 5'd0;
            vb_reg    <= 1'b0;
        end
        else if (proc)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            ts_reg    <= ts_next;
            tok_reg   <= tok_next;
            cnt_reg   <= cnt_next;
            cs_reg    <= cs_next;
            entry_reg <= entry_next;
            vb_reg    <= vb_next;
        end
    end

    `HRHP_ASSERT_IMPLIES(a_silent_after_end, clk, rst_n, proc && !in_last_reg && (phase_reg == PH_DONE || phase_reg == PH_ERROR), push.count == 2'd0, "result after headers end or error")
    `HRHP_ASSERT_NEXT(a_restart_after_last, clk, rst_n, proc && in_last_reg, phase_reg == PH_METHOD && pos_reg == '0, "parse not restarted after last byte")

endmodule

FILE: rtl/core/hrhp_result_fifo.sv
`include "http_request_header_parser_defines.svh"

module hrhp_result_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hrhp_pkg::result_push_t push,
    output logic                   room,
    hrhp_out_if.source             result_stream
);
    import hrhp_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    result_t              mem_reg [RES_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 pop;
    logic [CNT_W-1:0]     count_after_pop;
    result_t              head;

    assign pop             = (count_reg != '0) && result_stream.ready;
    assign count_after_pop = count_reg - CNT_W'(pop);
    // Space for the worst case of two results from one byte
    assign room            = count_after_pop <= CNT_W'(RES_DEPTH - 2);

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_after_pop + CNT_W'(push.count);

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.rec0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push.rec1;
        end
    end

    // Head of queue drives the result channel
    assign head                       = mem_reg[rd_ptr_reg];
    assign result_stream.valid        = count_reg != '0;
    assign result_stream.event_kind   = head.kind;
    assign result_stream.kind_code    = head.code;
    assign result_stream.field_start  = head.start;
    assign result_stream.field_length = head.length;
    assign result_stream.header_index = head.index;
    assign result_stream.last_result  = head.last;

    `HRHP_ASSERT_IMPLIES(a_push_needs_room, clk, rst_n, push.count != 2'd0, room, "result pushed without room")
    `HRHP_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(RES_DEPTH), "result queue overflow")

endmodule

FILE: sim/hrhp_record_check.sv
// Watches the byte, record and config channels of the header parser, predicts
// the records each accepted byte must produce and compares them in order.
module hrhp_record_check (
    input  logic clk,
    input  logic rst_n,
    hrhp_in_if   byte_mon,
    hrhp_out_if  rec_mon,
    hrhp_cfg_if  cfg_mon,
    output int   open_records,
    output int   mismatch_count
);
    import hrhp_pkg::*;

    localparam logic [4:0] TABLE_CAP      = 5'd16;
    localparam logic [4:0] LIMIT_AT_RESET = 5'd16;

    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_LF    = 8'h0A;
    localparam logic [7:0] ASCII_COLON = 8'h3A;
    localparam logic [7:0] ASCII_SPACE = 8'h20;

    localparam int NO_MATCH       = -1;
    localparam int METHOD_GET     = 0;
    localparam int METHOD_POST    = 1;
    localparam int METHOD_PUSH    = 2;
    localparam int METHOD_DELETE  = 3;
    localparam int METHOD_CONNECT = 4;
    localparam int VERSION_1_0    = 0;
    localparam int VERSION_1_1    = 1;
    localparam int VERSION_2_0    = 2;

    // Shadow copy of the parser state
    phase_t      parse_state;
    logic [15:0] byte_pos;
    logic [15:0] field_base;
    logic [63:0] tok_bytes;
    logic [3:0]  tok_len;
    logic        cr_pending;
    logic [4:0]  entry_idx;
    logic        value_started;
    logic [4:0]  max_headers_reg;

    result_t byte_records[$];
    result_t pending_records[$];
    int      error_tally;

    function automatic int method_code(input logic [63:0] t, input logic [3:0] n);
        if (n == 4'd3 && t == 64'("GET"))     return METHOD_GET;
        if (n == 4'd4 && t == 64'("POST"))    return METHOD_POST;
        if (n == 4'd4 && t == 64'("PUSH"))    return METHOD_PUSH;
        if (n == 4'd6 && t == 64'("DELETE"))  return METHOD_DELETE;
        if (n == 4'd7 && t == 64'("CONNECT")) return METHOD_CONNECT;
        return NO_MATCH;
    endfunction

    function automatic int version_code(input logic [63:0] t, input logic [3:0] n);
        if (n == 4'd8 && t == 64'("HTTP/1.0")) return VERSION_1_0;
        if (n == 4'd8 && t == 64'("HTTP/1.1")) return VERSION_1_1;
        if (n == 4'd8 && t == 64'("HTTP/2.0")) return VERSION_2_0;
        return NO_MATCH;
    endfunction

    task automatic restart_parse();
        parse_state   = PH_METHOD;
        byte_pos      = '0;
        field_base    = '0;
        tok_bytes     = '0;
        tok_len       = '0;
        cr_pending    = 1'b0;
        entry_idx     = '0;
        value_started = 1'b0;
    endtask

    // Keep the last eight token bytes, count saturates at 15
    task automatic shift_token(input logic [7:0] b);
        tok_bytes = {tok_bytes[55:0], b};
        if (tok_len != 4'd15)
            tok_len = tok_len + 4'd1;
    endtask

    task automatic drop_token();
        tok_bytes  = '0;
        tok_len    = '0;
        cr_pending = 1'b0;
    endtask

    task automatic emit(input event_kind_t kind, input logic [2:0] code,
                        input logic [15:0] start, input logic [15:0] len,
                        input logic [4:0] idx);
        result_t r;
        r.kind   = kind;
        r.code   = code;
        r.start  = start;
        r.length = len;
        r.index  = idx;
        r.last   = 1'b0;
        byte_records.push_back(r);
    endtask

    // Advance the shadow parser by one byte and queue the records it yields
    task automatic parse_request_byte(input logic [7:0] b, input logic final_byte);
        logic [15:0] pos;
        logic [15:0] nxt;
        logic [4:0]  limit;
        logic        line_end;
        int          code;
        result_t     r;
        pos      = byte_pos;
        nxt      = byte_pos + 16'd1;
        line_end = 1'b0;
        limit    = (max_headers_reg < TABLE_CAP) ? max_headers_reg : TABLE_CAP;
        byte_records.delete();

        // CR LF may be split over two bytes; a lone CR joins the token
        if (parse_state inside {PH_VERSION, PH_KEY, PH_VALUE})
        begin
            if (cr_pending && b == ASCII_LF)
            begin
                line_end   = 1'b1;
                cr_pending = 1'b0;
            end
            else if (b == ASCII_CR)
            begin
                if (cr_pending)
                    shift_token(ASCII_CR);
                cr_pending = 1'b1;
            end
            else
            begin
                if (cr_pending)
                    shift_token(ASCII_CR);
                cr_pending = 1'b0;
            end
        end

        case (parse_state)
            PH_METHOD:
            begin
                if (b == ASCII_SPACE)
                begin
                    code = method_code(tok_bytes, tok_len);
                    if (code == NO_MATCH)
                    begin
                        emit(EV_ERROR, ERR_METHOD, pos, 16'd0, 5'd0);
                        parse_state = PH_ERROR;
                    end
                    else
                    begin
                        emit(EV_METHOD, 3'(code), field_base, pos - field_base, 5'd0);
                        parse_state = PH_PATH;
                        field_base  = nxt;
                    end
                    drop_token();
                end
                else
                    shift_token(b);
            end
            PH_PATH:
            begin
                if (b == ASCII_SPACE)
                begin
                    emit(EV_PATH, CODE_NONE, field_base, pos - field_base, 5'd0);
                    parse_state = PH_VERSION;
                    field_base  = nxt;
                    drop_token();
                end
            end
            PH_VERSION:
            begin
                if (line_end)
                begin
                    code = version_code(tok_bytes, tok_len);
                    if (code == NO_MATCH)
                    begin
                        emit(EV_ERROR, ERR_VERSION, pos, 16'd0, 5'd0);
                        parse_state = PH_ERROR;
                    end
                    else
                    begin
                        emit(EV_VERSION, 3'(code), field_base, pos - 16'd1 - field_base, 5'd0);
                        entry_idx = '0;
                        if (limit == 5'd0)
                        begin
                            emit(EV_ERROR, ERR_NO_ROOM, pos, 16'd0, 5'd0);
                            parse_state = PH_ERROR;
                        end
                        else
                        begin
                            parse_state = PH_KEY;
                            field_base  = nxt;
                        end
                    end
                    drop_token();
                end
                else if (b != ASCII_CR)
                    shift_token(b);
            end
            PH_KEY:
            begin
                // empty line or a line without colon closes the headers
                if (line_end)
                begin
                    emit(EV_HEADERS_END, CODE_NONE, nxt, 16'd0, entry_idx);
                    parse_state = PH_DONE;
                end
                else if (b == ASCII_COLON)
                begin
                    emit(EV_KEY, CODE_NONE, field_base, pos - field_base, entry_idx);
                    parse_state   = PH_VALUE;
                    field_base    = nxt;
                    value_started = 1'b0;
                    cr_pending    = 1'b0;
                end
            end
            PH_VALUE:
            begin
                if (line_end)
                begin
                    emit(EV_VALUE, CODE_NONE, field_base, pos - 16'd1 - field_base, entry_idx);
                    entry_idx = entry_idx + 5'd1;
                    if (entry_idx >= limit)
                    begin
                        emit(EV_ERROR, ERR_TABLE_FULL, pos, 16'd0, 5'd0);
                        parse_state = PH_ERROR;
                    end
                    else
                    begin
                        parse_state = PH_KEY;
                        field_base  = nxt;
                    end
                end
                else if (b == ASCII_SPACE && !value_started)
                    field_base = nxt;
                else
                    value_started = 1'b1;
            end
            default:
            begin
            end
        endcase

        byte_pos = nxt;

        // End of buffer: report an open parse, then start over
        if (final_byte)
        begin
            if (parse_state != PH_DONE && parse_state != PH_ERROR)
                emit(EV_EXHAUSTED, CODE_NONE, nxt, 16'd0, 5'd0);
            restart_parse();
        end

        if (byte_records.size() > 0)
        begin
            r = byte_records.pop_back();
            r.last = 1'b1;
            byte_records.push_back(r);
        end
        foreach (byte_records[i])
            pending_records.push_back(byte_records[i]);
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            error_tally++;
        end
    endtask

    task automatic check_record();
        result_t want;
        if (pending_records.size() == 0)
        begin
            $display("%0t: record with none expected, actual kind %0d start %0d",
                     $time, rec_mon.event_kind, rec_mon.field_start);
            error_tally++;
        end
        else
        begin
            want = pending_records.pop_front();
            check_field("event_kind", 16'(want.kind), 16'(rec_mon.event_kind));
            check_field("kind_code", 16'(want.code), 16'(rec_mon.kind_code));
            check_field("field_start", want.start, rec_mon.field_start);
            check_field("field_length", want.length, rec_mon.field_length);
            check_field("header_index", 16'(want.index), 16'(rec_mon.header_index));
            check_field("last_result", 16'(want.last), 16'(rec_mon.last_result));
        end
    endtask

    // One pass per edge: config write, record compare, then byte prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_parse();
            max_headers_reg = LIMIT_AT_RESET;
            pending_records.delete();
            error_tally    = 0;
            open_records   <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
                max_headers_reg = cfg_mon.max_headers;
            if (rec_mon.valid && rec_mon.ready)
                check_record();
            if (byte_mon.valid && byte_mon.ready)
                parse_request_byte(byte_mon.data_byte, byte_mon.last_byte);
            open_records   <= pending_records.size();
            mismatch_count <= error_tally;
        end
    end

endmodule

FILE: sim/http_request_header_parser_tb.sv
// Stimulus and verdict for the HTTP request header parser.
module http_request_header_parser_tb;

    localparam int CYCLE_LIMIT  = 500_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 700;

    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_COLON = 8'h3A;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_SLASH = 8'h2F;
    localparam string      EOL         = "\015\012";

    // Kinds of damage applied to a generated request
    localparam int FLAW_METHOD   = 0;
    localparam int FLAW_VERSION  = 1;
    localparam int FLAW_TRUNCATE = 2;
    localparam int FLAW_STRAY_CR = 3;
    localparam int FLAW_NO_COLON = 4;

    localparam logic [4:0] SETTING_LIST [8] = '{5'd0, 5'd16, 5'd1, 5'd2,
                                                5'd3, 5'd8, 5'd15, 5'd5};

    logic clk;
    logic rst_n;
    int   open_records;
    int   mismatch_count;
    int   cycle_count;
    int   bytes_sent;
    int   hdr_limit;
    bit   idle_on;
    bit   hold_go;

    logic [7:0] req_bytes[$];
    string method_txt [5]      = '{"GET", "POST", "PUSH", "DELETE", "CONNECT"};
    string version_txt [3]     = '{"HTTP/1.0", "HTTP/1.1", "HTTP/2.0"};
    string bad_version_txt [4] = '{"HTTP/1.2", "HTTP/1.", "HTTP/1.10", "http/1.1"};

    hrhp_in_if  byte_if ();
    hrhp_out_if rec_if ();
    hrhp_cfg_if cfg_if ();

    http_request_header_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_stream   (byte_if),
        .result_stream (rec_if),
        .cfg           (cfg_if)
    );

    hrhp_record_check u_record_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_mon       (byte_if),
        .rec_mon        (rec_if),
        .cfg_mon        (cfg_if),
        .open_records   (open_records),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d records still expected", $time, open_records);
        $display("RESULT: ERROR");
        $finish;
    end

    // Record sink: random stalls, one long hold-off on request
    initial
    begin
        rec_if.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_go)
            begin
                hold_go = 1'b0;
                rec_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                rec_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                rec_if.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // One byte transaction, with an occasional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b, input logic lst);
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= b;
        byte_if.last_byte <= lst;
        @(posedge clk);
        while (!byte_if.ready) @(posedge clk);
        bytes_sent++;
    endtask

    // Send the assembled buffer, flagging its final byte
    task automatic send_request();
        foreach (req_bytes[i])
            send_byte(req_bytes[i], i == req_bytes.size() - 1);
        req_bytes.delete();
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            req_bytes.push_back(s[i]);
    endfunction

    task automatic send_text(input string s);
        add_text(s);
        send_request();
    endtask

    function automatic logic [7:0] rand_byte_except(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        while (v == a || v == b)
            v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    // Mostly well-formed request with random content, sometimes damaged
    function automatic void build_request();
        int flaw;
        int span;
        int n_hdr;
        flaw = $urandom_range(0, 9);
        if (flaw == FLAW_METHOD)
        begin
            repeat ($urandom_range(0, 8))
                req_bytes.push_back(8'($urandom_range(8'h41, 8'h5A)));
        end
        else
            add_text(method_txt[$urandom_range(0, 4)]);
        req_bytes.push_back(ASCII_SPACE);
        req_bytes.push_back(ASCII_SLASH);
        repeat ($urandom_range(0, 12))
            req_bytes.push_back(rand_byte_except(ASCII_SPACE, ASCII_SPACE));
        req_bytes.push_back(ASCII_SPACE);
        if (flaw == FLAW_VERSION)
            add_text(bad_version_txt[$urandom_range(0, 3)]);
        else
            add_text(version_txt[$urandom_range(0, 2)]);
        add_text(EOL);

        // header count mostly small, now and then past the table limit
        span  = (hdr_limit < 4) ? hdr_limit + 1 : 4;
        n_hdr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, hdr_limit + 1)
                                            : $urandom_range(0, span);
        repeat (n_hdr)
        begin
            repeat ($urandom_range(0, 6))
                req_bytes.push_back(rand_byte_except(ASCII_COLON, ASCII_CR));
            req_bytes.push_back(ASCII_COLON);
            repeat ($urandom_range(0, 3))
                req_bytes.push_back(ASCII_SPACE);
            repeat ($urandom_range(0, 8))
                req_bytes.push_back(rand_byte_except(ASCII_CR, ASCII_CR));
            if (flaw == FLAW_STRAY_CR)
            begin
                req_bytes.push_back(ASCII_CR);
                add_text("x");
            end
            add_text(EOL);
        end
        if (flaw == FLAW_NO_COLON)
            add_text("NoColon");
        add_text(EOL);
        repeat ($urandom_range(0, 4))
            req_bytes.push_back(8'($urandom_range(0, 255)));
        if (flaw == FLAW_TRUNCATE)
            req_bytes = req_bytes[0:$urandom_range(0, req_bytes.size() - 1)];
    endfunction

    // Wait until all records are in and the pipeline has drained
    task automatic settle();
        byte_if.valid <= 1'b0;
        @(posedge clk);
        while (open_records != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_headers(input logic [4:0] v);
        settle();
        cfg_if.valid       <= 1'b1;
        cfg_if.max_headers <= v;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        hdr_limit = v;
    endtask

    initial
    begin
        int         setting_no;
        bit         pressure_done;
        logic [4:0] setting;
        rst_n              = 1'b0;
        byte_if.valid      = 1'b0;
        byte_if.data_byte  = 8'd0;
        byte_if.last_byte  = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.max_headers = 5'd0;
        idle_on            = 1'b1;
        hold_go            = 1'b0;
        bytes_sent         = 0;
        hdr_limit          = 16;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every method and version, field edge cases
        write_max_headers(5'd16);
        send_text("GET / HTTP/1.0\015\012\015\012");
        send_text("POST /a HTTP/1.1\015\012Host:  x y \015\012\015\012body");
        send_text("PUSH /p HTTP/2.0\015\012K:v\015z\015\012NoColon\015\012tail");
        send_text("DELETE /d HTTP/1.1\015\012:\015\012\015\012");
        send_text("CONNECT h:1 HTTP/1.0\015\012\015\012");
        send_text(" / HTTP/1.0\015\012");
        send_text("GETX / HTTP/1.0\015\012");
        send_text("GE / HTTP/1.1\015\012");
        send_text("GET / HTTP/1.01\015\012");
        send_text("GET / HTTP/1.\0151\015\012");
        send_text("GET /x HTTP/1.1\015\015\012\015\012");
        send_text("GET /trunc HTTP/1.");
        add_text("GET /");
        req_bytes.push_back(8'h00);
        req_bytes.push_back(8'hFF);
        add_text(" HTTP/1.1\015\012\015\012");
        req_bytes.push_back(8'hFF);
        send_request();
        req_bytes.push_back(8'hFF);
        send_request();

        // Fill the whole table and one more
        add_text("GET /full HTTP/1.1\015\012");
        for (int i = 0; i < 17; i++)
            add_text({$sformatf("K%0d: v", i), EOL});
        add_text(EOL);
        send_request();

        // No room with a zero limit, table full with a limit of one
        write_max_headers(5'd0);
        send_text("GET / HTTP/1.1\015\012A:b\015\012\015\012");
        write_max_headers(5'd1);
        send_text("POST / HTTP/1.1\015\012A: b\015\012C:d\015\012\015\012");

        // Random requests over several table limits
        setting_no    = 0;
        pressure_done = 1'b0;
        bytes_sent    = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            setting = (setting_no < 8) ? SETTING_LIST[setting_no] : 5'($urandom_range(0, 16));
            setting_no++;
            write_max_headers(setting);
            if (!pressure_done && bytes_sent > RANDOM_BYTES / 3)
            begin
                hold_go       = 1'b1;
                pressure_done = 1'b1;
            end
            repeat ($urandom_range(2, 4))
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    repeat ($urandom_range(1, 20))
                        req_bytes.push_back(8'($urandom_range(0, 255)));
                end
                else
                    build_request();
                send_request();
            end
            if (bytes_sent > RANDOM_BYTES * 3 / 4)
                idle_on = 1'b0;
        end

        settle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
